>>> hdl/sart_pkg.sv
// sart_pkg: shared types and constants for the sorted address range table
// holds the entry record, the cell control word and the command and status codes
// no dependencies

package sart_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 64;
   localparam int FSIZE_W     = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_CNT_W = 7;
   localparam int REQ_DATA_W  = 160;
   localparam int RSP_DATA_W  = 168;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_UNREGISTER = 2'd1,
      CMD_LOOKUP     = 2'd2,
      CMD_CLEAR      = 2'd3
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_MISS    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_COMPARE,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  start_addr;
      logic [ADDR_W-1:0]  end_addr;
      logic [FSIZE_W-1:0] frame_bytes;
   } entry_type;

   typedef struct packed {
      cell_op_type        op;
      logic [ADDR_W-1:0]  probe;
      entry_type          fresh;
   } cell_ctrl_type;

endpackage

>>> hdl/sart_cell.sv
// sart_cell: one slot of the range table, holding an entry and its compare flags
// shifts towards either neighbour on insert or removal
// depends on sart_pkg

module sart_cell (
   input  logic                   clock,
   input  sart_pkg::cell_ctrl_type ctrl,
   input  logic                   valid,
   input  logic                   prefix_left,
   input  logic                   prefix_right,
   input  sart_pkg::entry_type    left_entry,
   input  sart_pkg::entry_type    right_entry,
   output sart_pkg::entry_type    entry_out,
   output logic                   prefix_out,
   output logic                   hit_out,
   output sart_pkg::entry_type    hit_entry
);
   import sart_pkg::*;

   entry_type entry_ff, entry_in;
   logic      le_ff, le_in;
   logic      lt_ff, lt_in;
   logic      below_end_ff, below_end_in;

   assign entry_out  = entry_ff;
   assign prefix_out = valid && le_ff;
   assign hit_out    = prefix_out && !prefix_right && below_end_ff;
   assign hit_entry  = hit_out ? entry_ff : '0;

   always_comb begin
      entry_in     = entry_ff;
      le_in        = le_ff;
      lt_in        = lt_ff;
      below_end_in = below_end_ff;
      case (ctrl.op)
         CELL_COMPARE: begin
            le_in        = entry_ff.start_addr <= ctrl.probe;
            lt_in        = entry_ff.start_addr < ctrl.probe;
            below_end_in = ctrl.probe < entry_ff.end_addr;
         end
         CELL_INSERT: begin
            if (!prefix_out) begin
               entry_in = prefix_left ? ctrl.fresh : left_entry;
            end
         end
         CELL_DELETE: begin
            if (!(valid && lt_ff)) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      le_ff        <= le_in;
      lt_ff        <= lt_in;
      below_end_ff <= below_end_in;
   end

endmodule

>>> hdl/sorted_address_range_table.sv
// sorted_address_range_table: one transaction in, one result out; the result is registered
// after the compare then apply states (shift or select); next command taken as it leaves
// no new command is taken until the last has left the compare and apply passes of the cell row
// a result waiting on rsp_tready holds the apply step; a fresh command is still taken meanwhile
// synchronous reset empties the table and clears handshake state; entry contents are not cleared
// depends on sart_pkg and sart_cell

module sorted_address_range_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // address, end_address, stack frame size
   input  logic [sart_pkg::REQ_DATA_W-1:0]   req_tdata,
   // command
   input  logic [sart_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_start, entry_end, entry_frame_size, entry_count, zero pad
   output logic [sart_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [sart_pkg::STATUS_W-1:0]     rsp_tuser
);
   import sart_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY
   } state_type;

   state_type          state_ff;
   command_type        cmd_ff;
   entry_type          req_ff;
   logic               invalid_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   entry_type          out_entry_ff, out_entry_in;

   cell_ctrl_type      ctrl;
   logic [TABLE_DEPTH-1:0] valid_vec;
   logic [TABLE_DEPTH:0]   prefix;
   logic [TABLE_DEPTH-1:0] hit_vec;
   entry_type          cell_entry [TABLE_DEPTH+1];
   entry_type          hit_entry  [TABLE_DEPTH];
   entry_type          hit_sum;
   logic               found;
   logic               any_hit;
   logic               full;
   logic               apply_go;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {1'b0, ENTRY_CNT_W'(count_ff), out_entry_ff.frame_bytes,
                        out_entry_ff.end_addr, out_entry_ff.start_addr};

   assign full     = (count_ff == COUNT_W'(TABLE_DEPTH));
   assign apply_go = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         valid_vec[i] = COUNT_W'(i) < count_ff;
      end
   end

   always_comb begin
      found   = 1'b0;
      any_hit = 1'b0;
      hit_sum = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         found   = found | (prefix[i+1]
                            && (cell_entry[i].start_addr == req_ff.start_addr));
         any_hit = any_hit | hit_vec[i];
         hit_sum = hit_sum | hit_entry[i];
      end
   end

   assign prefix[0]                 = 1'b1;
   assign cell_entry[TABLE_DEPTH]   = '0;

   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.probe = req_ff.start_addr;
      ctrl.fresh = req_ff;
      if (state_ff == S_COMPARE) begin
         ctrl.op = CELL_COMPARE;
      end else if (apply_go) begin
         if (cmd_ff == CMD_REGISTER && !invalid_ff && !full) begin
            ctrl.op = CELL_INSERT;
         end else if (cmd_ff == CMD_UNREGISTER && found) begin
            ctrl.op = CELL_DELETE;
         end
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic prefix_right;
      if (g == TABLE_DEPTH - 1) begin : g_last
         assign prefix_right = 1'b0;
      end else begin : g_mid
         assign prefix_right = prefix[g+2];
      end
      sart_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .valid        (valid_vec[g]),
         .prefix_left  (prefix[g]),
         .prefix_right (prefix_right),
         .left_entry   (g == 0 ? req_ff : cell_entry[(g == 0) ? 0 : g - 1]),
         .right_entry  (cell_entry[g+1]),
         .entry_out    (cell_entry[g]),
         .prefix_out   (prefix[g+1]),
         .hit_out      (hit_vec[g]),
         .hit_entry    (hit_entry[g])
      );
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = STATUS_OK;
      out_entry_in = '0;
      case (cmd_ff)
         CMD_REGISTER: begin
            if (invalid_ff) begin
               status_in = STATUS_INVALID;
            end else if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         CMD_UNREGISTER: begin
            if (found) begin
               count_in = count_ff - COUNT_W'(1);
            end else begin
               status_in = STATUS_MISS;
            end
         end
         CMD_LOOKUP: begin
            if (any_hit) begin
               out_entry_in = hit_sum;
            end else begin
               status_in = STATUS_MISS;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !apply_go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_COMPARE;
               end
            end
            S_COMPARE: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (apply_go) begin
                  state_ff     <= S_IDLE;
                  count_ff     <= count_in;
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= status_in;
                  out_entry_ff <= out_entry_in;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         cmd_ff             <= command_type'(req_tuser);
         req_ff.start_addr  <= req_tdata[ADDR_W-1:0];
         req_ff.end_addr    <= req_tdata[2*ADDR_W-1:ADDR_W];
         req_ff.frame_bytes <= req_tdata[2*ADDR_W+FSIZE_W-1:2*ADDR_W];
      end
      if (state_ff == S_COMPARE) begin
         invalid_ff <= (req_ff.start_addr == '0) || (req_ff.end_addr == '0)
                       || (req_ff.start_addr >= req_ff.end_addr);
      end
   end

endmodule
